// ===== rtl/nps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nps_pkg: shared types and constants of the next prime search core
// Field widths, parameter defaults and the sequencer state encoding.
// ----------------------------------------------------------------------------
package nps_pkg;

   // Payload field widths
   localparam int START_BITS = 32;
   localparam int PRIME_BITS = 31;

   // Default search ceiling exponent: ceiling is 2^VALUE_BITS - 1
   localparam int DEF_VALUE_BITS = 31;

   // Smallest prime, returned for every start value below two
   localparam int SMALLEST_PRIME = 2;

   // First odd trial divisor
   localparam int FIRST_DIVISOR = 3;

   // Sequencer states, one-hot
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CHECK  = 7'b0000010,
      ST_SQRT   = 7'b0000100,
      ST_TRIAL  = 7'b0001000,
      ST_DIVIDE = 7'b0010000,
      ST_NEXT   = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

endpackage : nps_pkg
`default_nettype wire

// ===== rtl/next_prime_search_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// next_prime_search_core: smallest prime not below a signed start value
// One item at a time; trial division by odd divisors up to the floor root,
// with root and remainder steps on one shared subtract-and-compare unit.
// ----------------------------------------------------------------------------
// Sequence: a start below two gives two, a start above the ceiling is returned as is.
//   Else candidates from the start are checked in turn, the start coming back if the
//   ceiling is reached: two is prime, even values move on, odd ones take a root
//   extraction and a remainder per odd divisor, one bit per cycle on the subtractor.
// Flow: one item at a time; the request is stalled until the result is taken.
// Reset: synchronous, active high; returns to idle with no result pending.

module next_prime_search_core #(
   parameter int VALUE_BITS = nps_pkg::DEF_VALUE_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [nps_pkg::START_BITS-1:0]  req_start_value,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [nps_pkg::PRIME_BITS-1:0]       rsp_prime_found
);
   import nps_pkg::*;

   // Derived widths
   localparam int CAND_BITS = (VALUE_BITS < PRIME_BITS) ? VALUE_BITS : PRIME_BITS;
   localparam int ROOT_BITS = (CAND_BITS + 1) / 2;
   localparam int PAD_BITS  = 2 * ROOT_BITS;
   localparam int DIV_BITS  = ROOT_BITS + 1;
   localparam int SUB_BITS  = ROOT_BITS + 2;
   localparam int CNT_BITS  = $clog2(CAND_BITS + 1);
   localparam logic [63:0] CEILING = (64'd1 << VALUE_BITS) - 64'd1;

   // Registers
   state_type              state_ff,   state_in;
   logic [PRIME_BITS-1:0]  start_ff,   start_in;
   logic [CAND_BITS-1:0]   cand_ff,    cand_in;
   logic [PAD_BITS-1:0]    work_ff,    work_in;
   logic [SUB_BITS-1:0]    rem_ff,     rem_in;
   logic [ROOT_BITS-1:0]   root_ff,    root_in;
   logic [ROOT_BITS-1:0]   limit_ff,   limit_in;
   logic [DIV_BITS-1:0]    divisor_ff, divisor_in;
   logic [CNT_BITS-1:0]    count_ff,   count_in;
   logic [PRIME_BITS-1:0]  result_ff,  result_in;

   // Shared unit signals
   logic [SUB_BITS-1:0]    sqrt_shift;
   logic [SUB_BITS-1:0]    div_shift;
   logic [SUB_BITS-1:0]    op_a;
   logic [SUB_BITS-1:0]    op_b;
   logic [SUB_BITS:0]      diff;
   logic                   fits;
   logic [SUB_BITS-1:0]    keep;

   logic                   req_xfer;
   logic                   last_step;
   logic                   at_ceiling;
   logic                   above_ceiling;

   assign req_xfer      = req_valid && !req_stall;
   assign last_step     = (count_ff == CNT_BITS'(1));
   assign at_ceiling    = ({{(64-CAND_BITS){1'b0}}, cand_ff} >= CEILING);
   assign above_ceiling = ({32'd0, req_start_value} > CEILING);

   // Shared subtract-and-compare unit: root digit step or remainder bit step
   always_comb begin
      sqrt_shift = {rem_ff[SUB_BITS-3:0], work_ff[PAD_BITS-1 -: 2]};
      div_shift  = {rem_ff[SUB_BITS-2:0], work_ff[PAD_BITS-1]};
      if (state_ff == ST_SQRT) begin
         op_a = sqrt_shift;
         op_b = {root_ff, 2'b01};
      end else begin
         op_a = div_shift;
         op_b = {1'b0, divisor_ff};
      end
      diff = {1'b0, op_a} - {1'b0, op_b};
      fits = !diff[SUB_BITS];
      keep = fits ? diff[SUB_BITS-1:0] : op_a;
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      start_in   = start_ff;
      cand_in    = cand_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      limit_in   = limit_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      result_in  = result_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               start_in = req_start_value[PRIME_BITS-1:0];
               cand_in  = req_start_value[CAND_BITS-1:0];
               if (req_start_value[START_BITS-1] ||
                   (req_start_value < START_BITS'(SMALLEST_PRIME))) begin
                  result_in = PRIME_BITS'(SMALLEST_PRIME);
                  state_in  = ST_DONE;
               end else if (above_ceiling) begin
                  result_in = req_start_value[PRIME_BITS-1:0];
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end

         ST_CHECK: begin
            // Two is prime, other even values are not; odd ones need the root
            if (cand_ff == CAND_BITS'(SMALLEST_PRIME)) begin
               result_in = PRIME_BITS'(cand_ff);
               state_in  = ST_DONE;
            end else if (!cand_ff[0]) begin
               state_in = ST_NEXT;
            end else begin
               work_in  = PAD_BITS'(cand_ff);
               rem_in   = '0;
               root_in  = '0;
               count_in = CNT_BITS'(ROOT_BITS);
               state_in = ST_SQRT;
            end
         end

         ST_SQRT: begin
            // Retire one root bit per cycle
            work_in  = work_ff << 2;
            rem_in   = keep;
            root_in  = {root_ff[ROOT_BITS-2:0], fits};
            count_in = count_ff - CNT_BITS'(1);
            if (last_step) begin
               limit_in   = {root_ff[ROOT_BITS-2:0], fits};
               divisor_in = DIV_BITS'(FIRST_DIVISOR);
               state_in   = ST_TRIAL;
            end
         end

         ST_TRIAL: begin
            // Past the root with no divisor found: prime
            if ({1'b0, limit_ff} < divisor_ff) begin
               result_in = PRIME_BITS'(cand_ff);
               state_in  = ST_DONE;
            end else begin
               work_in  = PAD_BITS'(cand_ff) << (PAD_BITS - CAND_BITS);
               rem_in   = '0;
               count_in = CNT_BITS'(CAND_BITS);
               state_in = ST_DIVIDE;
            end
         end

         ST_DIVIDE: begin
            // Restoring remainder, one candidate bit per cycle
            work_in  = work_ff << 1;
            rem_in   = keep;
            count_in = count_ff - CNT_BITS'(1);
            if (last_step) begin
               if (keep == '0) begin
                  state_in = ST_NEXT;
               end else begin
                  divisor_in = divisor_ff + DIV_BITS'(2);
                  state_in   = ST_TRIAL;
               end
            end
         end

         ST_NEXT: begin
            // Advance the candidate, or fall back to the start at the ceiling
            if (at_ceiling) begin
               result_in = start_ff;
               state_in  = ST_DONE;
            end else begin
               cand_in  = cand_ff + CAND_BITS'(1);
               state_in = ST_CHECK;
            end
         end

         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      start_ff   <= start_in;
      cand_ff    <= cand_in;
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      limit_ff   <= limit_in;
      divisor_ff <= divisor_in;
      count_ff   <= count_in;
      result_ff  <= result_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_DONE);
   assign rsp_prime_found = result_ff;

   // Checks
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < {1'b0, divisor_ff}))
      else $error("remainder not below divisor");

   a_divisor_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRIAL) |-> divisor_ff[0])
      else $error("trial divisor is even");

   a_result_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_prime_found >= PRIME_BITS'(SMALLEST_PRIME)))
      else $error("result below two");

   a_negative_fast: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_start_value[START_BITS-1]) |=>
         (rsp_valid && (rsp_prime_found == PRIME_BITS'(SMALLEST_PRIME))))
      else $error("negative start did not return two");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("result repeated after transfer");

endmodule : next_prime_search_core
`default_nettype wire
